// ===== hdl/fia_pkg.sv =====
// Shared types, constants and tables for the field-of-view information accumulator.
`timescale 1ns / 1ps

package fia_pkg;

   localparam int VW = 34;           // normalized vector / CORDIC lane width
   localparam int MW = 35;           // shared multiplier operand width
   localparam int PW = 2 * MW;       // product width
   localparam int QW = 20;           // weight quotient bits
   localparam int CNT_W = 6;         // sequencer counter width
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CSR_IW-1:0] CSR_SENSOR_X  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SENSOR_Y  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_SENSOR_Z  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_HEADING   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_HALF_VIEW = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_RANGE_MIN = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_RANGE_MAX = 3'd6;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_NORM_LOAD2,
      OP_NORM_LOAD3,
      OP_NORM_STEP,
      OP_CORD_INIT,
      OP_CORD_STEP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      MS_NONE,
      MS_RX2,
      MS_RY2,
      MS_RZ2,
      MS_RMIN2,
      MS_RMAX2,
      MS_VX2,
      MS_VY2,
      MS_VZ2,
      MS_DOTX,
      MS_DOTY,
      MS_DOTZ,
      MS_WA,
      MS_WAB
   } mul_sel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ,
      S_SQ_DRAIN,
      S_RANGE,
      S_NORM2,
      S_CORD,
      S_AZ,
      S_NORM3,
      S_MUL3,
      S_MUL3_DRAIN,
      S_SQRT,
      S_DIV_INIT,
      S_DIV,
      S_TERM,
      S_TERM_DRAIN,
      S_FINISH,
      S_EMIT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type mul;
      logic [2:0]  term;
      logic [4:0]  iter;
   } dp_cmd_type;

   typedef struct packed {
      logic keep_range;
      logic keep_az;
      logic norm_done;
      logic norm_zero;
      logic last;
      logic out_free;
   } dp_status_type;

   // atan(2^-i) in units of 2^32 per turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0:  atan_turn = 32'h20000000;
         5'd1:  atan_turn = 32'h12E4051E;
         5'd2:  atan_turn = 32'h09FB385B;
         5'd3:  atan_turn = 32'h051111D4;
         5'd4:  atan_turn = 32'h028B0D43;
         5'd5:  atan_turn = 32'h0145D7E1;
         5'd6:  atan_turn = 32'h00A2F61E;
         5'd7:  atan_turn = 32'h00517C55;
         5'd8:  atan_turn = 32'h0028BE53;
         5'd9:  atan_turn = 32'h00145F2F;
         5'd10: atan_turn = 32'h000A2F98;
         5'd11: atan_turn = 32'h000517CC;
         5'd12: atan_turn = 32'h00028BE6;
         5'd13: atan_turn = 32'h000145F3;
         5'd14: atan_turn = 32'h0000A2FA;
         5'd15: atan_turn = 32'h0000517D;
         5'd16: atan_turn = 32'h000028BE;
         5'd17: atan_turn = 32'h0000145F;
         5'd18: atan_turn = 32'h00000A30;
         5'd19: atan_turn = 32'h00000518;
         5'd20: atan_turn = 32'h0000028C;
         5'd21: atan_turn = 32'h00000146;
         5'd22: atan_turn = 32'h000000A3;
         5'd23: atan_turn = 32'h00000051;
         5'd24: atan_turn = 32'h00000029;
         5'd25: atan_turn = 32'h00000014;
         5'd26: atan_turn = 32'h0000000A;
         5'd27: atan_turn = 32'h00000005;
         5'd28: atan_turn = 32'h00000003;
         5'd29: atan_turn = 32'h00000001;
         5'd30: atan_turn = 32'h00000001;
         default: atan_turn = 32'h00000000;
      endcase
   endfunction

   // row / column of the k-th unique matrix entry: xx xy xz yy yz zz
   function automatic logic [1:0] term_row(input logic [2:0] k);
      case (k)
         3'd3, 3'd4: term_row = 2'd1;
         3'd5:       term_row = 2'd2;
         default:    term_row = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] term_col(input logic [2:0] k);
      case (k)
         3'd1, 3'd3:       term_col = 2'd1;
         3'd2, 3'd4, 3'd5: term_col = 2'd2;
         default:          term_col = 2'd0;
      endcase
   endfunction

endpackage

// ===== hdl/fia_ifs.sv =====
// Point request and matrix response channel interfaces.
`timescale 1ns / 1ps

interface fia_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               last_point;

   modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                   last_point, input ready);
   modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                 last_point, output ready);
endinterface

interface fia_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] info_xx;
   logic signed [63:0] info_xy;
   logic signed [63:0] info_xz;
   logic signed [63:0] info_yy;
   logic signed [63:0] info_yz;
   logic signed [63:0] info_zz;
   logic               saturated;

   modport source (output valid, info_xx, info_xy, info_xz, info_yy, info_yz, info_zz,
                   saturated, input ready);
   modport sink (input valid, info_xx, info_xy, info_xz, info_yy, info_yz, info_zz,
                 saturated, output ready);
endinterface

// ===== hdl/fia_ctrl.sv =====
// Sequencer for the accumulator: steps the datapath through range, azimuth, weight, sums.
`timescale 1ns / 1ps

module fia_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fia_pkg::dp_status_type status,
   output fia_pkg::dp_cmd_type    cmd
);

   localparam int CW = fia_pkg::CNT_W;

   fia_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fia_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd.op    = fia_pkg::OP_IDLE;
      cmd.mul   = fia_pkg::MS_NONE;
      cmd.term  = cnt_ff[3:1];
      cmd.iter  = cnt_ff[4:0];
      case (state_ff)
         fia_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = fia_pkg::OP_LOAD;
               cnt_in   = '0;
               state_in = fia_pkg::S_SQ;
            end
         end
         fia_pkg::S_SQ: begin
            case (cnt_ff[2:0])
               3'd0:    cmd.mul = fia_pkg::MS_RX2;
               3'd1:    cmd.mul = fia_pkg::MS_RY2;
               3'd2:    cmd.mul = fia_pkg::MS_RZ2;
               3'd3:    cmd.mul = fia_pkg::MS_RMIN2;
               default: cmd.mul = fia_pkg::MS_RMAX2;
            endcase
            if (cnt_ff == CW'(4)) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_SQ_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fia_pkg::S_SQ_DRAIN: state_in = fia_pkg::S_RANGE;
         fia_pkg::S_RANGE: begin
            if (status.keep_range) begin
               cmd.op   = fia_pkg::OP_NORM_LOAD2;
               state_in = fia_pkg::S_NORM2;
            end else begin
               state_in = fia_pkg::S_FINISH;
            end
         end
         fia_pkg::S_NORM2: begin
            if (status.norm_zero || status.norm_done) begin
               // normalized: start the rotations; with no horizontal offset azimuth stays zero, skip them
               cmd.op   = fia_pkg::OP_CORD_INIT;
               cnt_in   = '0;
               state_in = status.norm_zero ? fia_pkg::S_AZ : fia_pkg::S_CORD;
            end else begin
               cmd.op = fia_pkg::OP_NORM_STEP;
            end
         end
         fia_pkg::S_CORD: begin
            cmd.op = fia_pkg::OP_CORD_STEP;
            if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_AZ;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fia_pkg::S_AZ: begin
            if (status.keep_az) begin
               cmd.op   = fia_pkg::OP_NORM_LOAD3;
               state_in = fia_pkg::S_NORM3;
            end else begin
               state_in = fia_pkg::S_FINISH;
            end
         end
         fia_pkg::S_NORM3: begin
            if (status.norm_zero || status.norm_done) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_MUL3;
            end else begin
               cmd.op = fia_pkg::OP_NORM_STEP;
            end
         end
         fia_pkg::S_MUL3: begin
            case (cnt_ff[2:0])
               3'd0:    cmd.mul = fia_pkg::MS_VX2;
               3'd1:    cmd.mul = fia_pkg::MS_VY2;
               3'd2:    cmd.mul = fia_pkg::MS_VZ2;
               3'd3:    cmd.mul = fia_pkg::MS_DOTX;
               3'd4:    cmd.mul = fia_pkg::MS_DOTY;
               default: cmd.mul = fia_pkg::MS_DOTZ;
            endcase
            if (cnt_ff == CW'(5)) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_MUL3_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fia_pkg::S_MUL3_DRAIN: begin
            // squared length is complete here, the dot product lands this cycle
            cmd.op   = fia_pkg::OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = fia_pkg::S_SQRT;
         end
         fia_pkg::S_SQRT: begin
            cmd.op = fia_pkg::OP_SQRT_STEP;
            if (cnt_ff == CW'(31)) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fia_pkg::S_DIV_INIT: begin
            cmd.op   = fia_pkg::OP_DIV_INIT;
            cnt_in   = '0;
            state_in = fia_pkg::S_DIV;
         end
         fia_pkg::S_DIV: begin
            cmd.op = fia_pkg::OP_DIV_STEP;
            if (cnt_ff == CW'(fia_pkg::QW - 1)) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_TERM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fia_pkg::S_TERM: begin
            // even count: w*|ni|, odd count: that product times |nj|
            cmd.mul = cnt_ff[0] ? fia_pkg::MS_WAB : fia_pkg::MS_WA;
            if (cnt_ff == CW'(11)) begin
               cnt_in   = '0;
               state_in = fia_pkg::S_TERM_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fia_pkg::S_TERM_DRAIN: state_in = fia_pkg::S_FINISH;
         fia_pkg::S_FINISH: state_in = status.last ? fia_pkg::S_EMIT : fia_pkg::S_IDLE;
         fia_pkg::S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = fia_pkg::OP_EMIT;
               state_in = fia_pkg::S_IDLE;
            end
         end
         default: state_in = fia_pkg::S_IDLE;
      endcase
   end

endmodule

// ===== hdl/fia_dp.sv =====
// Datapath: registers, shared multiplier, normalizer, CORDIC, square root, divider, sums.
`timescale 1ns / 1ps

module fia_dp #(
   parameter int SUM_WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fia_pkg::CSR_IW-1:0]          csr_index,
   input  logic [fia_pkg::CSR_DW-1:0]          csr_wdata,
   input  logic signed [31:0]                  point_x,
   input  logic signed [31:0]                  point_y,
   input  logic signed [31:0]                  point_z,
   input  logic signed [15:0]                  normal_x,
   input  logic signed [15:0]                  normal_y,
   input  logic signed [15:0]                  normal_z,
   input  logic                                last_point,
   input  fia_pkg::dp_cmd_type                 cmd,
   output fia_pkg::dp_status_type              status,
   fia_rsp_if.source                           rsp
);

   localparam int VW = fia_pkg::VW;
   localparam int MW = fia_pkg::MW;
   localparam int PW = fia_pkg::PW;
   localparam int QW = fia_pkg::QW;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      mag33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      mag16 = v[15] ? 16'(-v) : 16'(v);
   endfunction

   function automatic logic [VW-1:0] magv(input logic signed [VW-1:0] v);
      magv = v[VW-1] ? VW'(-v) : VW'(v);
   endfunction

   logic signed [31:0]    sensor_x_ff, sensor_y_ff, sensor_z_ff;
   logic [15:0]           heading_ff, half_view_ff;
   logic [30:0]           range_min_ff, range_max_ff;

   logic signed [32:0]    rel_ff [3];
   logic signed [15:0]    nrm_ff [3];
   logic                  last_ff;

   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]  prod_ff;
   fia_pkg::mul_sel_type  tag_ff;
   logic [2:0]            tag_term_ff;

   logic [66:0]           dsq_ff;
   logic [61:0]           rmin2_ff, rmax2_ff, r2_ff;
   logic signed [47:0]    dot_ff;

   logic signed [VW-1:0]  vec_ff [3];
   logic [31:0]           ang_ff;

   logic [61:0]           sq_x_ff;
   logic [62:0]           sq_res_ff, sq_bit_ff;
   logic [30:0]           rem_ff;
   logic [QW-1:0]         low_ff, quo_ff;

   logic signed [SUM_WIDTH-1:0] sum_ff [6];
   logic                  sat_ff;
   logic signed [63:0]    info_ff [6];
   logic                  info_sat_ff, out_valid_ff;

   // ---- combinational helpers
   logic [VW-1:0]         vm0, vm1, vm2, vmax01, vmax;
   logic                  norm_hi;
   logic signed [VW-1:0]  cx_sh, cy_sh;
   logic [31:0]           cord_atan;
   logic [15:0]           az16, az_diff, az_mag;
   logic [63:0]           sq_try;
   logic                  sq_take;
   logic [30:0]           root_q;
   logic [47:0]           dot_mag;
   logic [31:0]           div_try;
   logic                  div_take;
   logic [QW-1:0]         weight;
   logic [1:0]            row_sel, col_sel, row_tag, col_tag;
   logic [33:0]           term_mag;
   logic signed [35:0]    term_val;
   logic signed [SUM_WIDTH:0]   sum_ext;
   logic signed [SUM_WIDTH-1:0] sum_new;

   always_comb begin
      vm0     = magv(vec_ff[0]);
      vm1     = magv(vec_ff[1]);
      vm2     = magv(vec_ff[2]);
      vmax01  = (vm0 > vm1) ? vm0 : vm1;
      vmax    = (vmax01 > vm2) ? vmax01 : vm2;
      norm_hi = |vmax[VW-1:30];

      cx_sh     = vec_ff[0] >>> cmd.iter;
      cy_sh     = vec_ff[1] >>> cmd.iter;
      cord_atan = fia_pkg::atan_turn(cmd.iter);

      az16    = 16'((ang_ff + 32'h0000_8000) >> 16);
      az_diff = az16 - heading_ff;
      az_mag  = az_diff[15] ? 16'(16'd0 - az_diff) : az_diff;

      sq_try  = 64'(sq_res_ff) + 64'(sq_bit_ff);
      sq_take = 64'(sq_x_ff) >= sq_try;
      root_q  = sq_res_ff[30:0];

      dot_mag  = dot_ff[47] ? 48'(-dot_ff) : 48'(dot_ff);
      div_try  = {rem_ff, low_ff[QW-1]};
      div_take = div_try >= {1'b0, root_q};
      weight   = (root_q == '0) ? '0 : quo_ff;

      row_sel = fia_pkg::term_row(cmd.term);
      col_sel = fia_pkg::term_col(cmd.term);
      row_tag = fia_pkg::term_row(tag_term_ff);
      col_tag = fia_pkg::term_col(tag_term_ff);

      // round |w*ni*nj| to Q.28 and restore the sign
      term_mag = 34'((prod_ff[47:0] + 48'd8192) >> 14);
      term_val = (nrm_ff[row_tag][15] ^ nrm_ff[col_tag][15])
                 ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
      sum_ext  = (SUM_WIDTH+1)'(sum_ff[tag_term_ff]) + (SUM_WIDTH+1)'(term_val);
      if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
         sum_new = term_val[35] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_new = sum_ext[SUM_WIDTH-1:0];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul)
         fia_pkg::MS_RX2: begin
            mul_a = MW'(mag33(rel_ff[0]));
            mul_b = MW'(mag33(rel_ff[0]));
         end
         fia_pkg::MS_RY2: begin
            mul_a = MW'(mag33(rel_ff[1]));
            mul_b = MW'(mag33(rel_ff[1]));
         end
         fia_pkg::MS_RZ2: begin
            mul_a = MW'(mag33(rel_ff[2]));
            mul_b = MW'(mag33(rel_ff[2]));
         end
         fia_pkg::MS_RMIN2: begin
            mul_a = MW'(range_min_ff);
            mul_b = MW'(range_min_ff);
         end
         fia_pkg::MS_RMAX2: begin
            mul_a = MW'(range_max_ff);
            mul_b = MW'(range_max_ff);
         end
         fia_pkg::MS_VX2: begin
            mul_a = MW'(vec_ff[0]);
            mul_b = MW'(vec_ff[0]);
         end
         fia_pkg::MS_VY2: begin
            mul_a = MW'(vec_ff[1]);
            mul_b = MW'(vec_ff[1]);
         end
         fia_pkg::MS_VZ2: begin
            mul_a = MW'(vec_ff[2]);
            mul_b = MW'(vec_ff[2]);
         end
         fia_pkg::MS_DOTX: begin
            mul_a = MW'(nrm_ff[0]);
            mul_b = MW'(vec_ff[0]);
         end
         fia_pkg::MS_DOTY: begin
            mul_a = MW'(nrm_ff[1]);
            mul_b = MW'(vec_ff[1]);
         end
         fia_pkg::MS_DOTZ: begin
            mul_a = MW'(nrm_ff[2]);
            mul_b = MW'(vec_ff[2]);
         end
         fia_pkg::MS_WA: begin
            mul_a = MW'(weight);
            mul_b = MW'(mag16(nrm_ff[row_sel]));
         end
         fia_pkg::MS_WAB: begin
            // product register still holds w*|ni| from the previous cycle
            mul_a = prod_ff[MW-1:0];
            mul_b = MW'(mag16(nrm_ff[col_sel]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_x_ff  <= '0;
         sensor_y_ff  <= '0;
         sensor_z_ff  <= '0;
         heading_ff   <= '0;
         half_view_ff <= 16'd16384;
         range_min_ff <= '0;
         range_max_ff <= 31'd6553600;
      end else if (csr_we) begin
         case (csr_index)
            fia_pkg::CSR_SENSOR_X:  sensor_x_ff  <= csr_wdata;
            fia_pkg::CSR_SENSOR_Y:  sensor_y_ff  <= csr_wdata;
            fia_pkg::CSR_SENSOR_Z:  sensor_z_ff  <= csr_wdata;
            fia_pkg::CSR_HEADING:   heading_ff   <= csr_wdata[15:0];
            fia_pkg::CSR_HALF_VIEW: half_view_ff <= csr_wdata[15:0];
            fia_pkg::CSR_RANGE_MIN: range_min_ff <= csr_wdata[30:0];
            fia_pkg::CSR_RANGE_MAX: range_max_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // ---- point capture, multiplier and its accumulators
   always_ff @(posedge clock) begin
      if (cmd.op == fia_pkg::OP_LOAD) begin
         rel_ff[0] <= 33'(point_x) - 33'(sensor_x_ff);
         rel_ff[1] <= 33'(point_y) - 33'(sensor_y_ff);
         rel_ff[2] <= 33'(point_z) - 33'(sensor_z_ff);
         nrm_ff[0] <= normal_x;
         nrm_ff[1] <= normal_y;
         nrm_ff[2] <= normal_z;
         last_ff   <= last_point;
      end

      prod_ff     <= mul_a * mul_b;
      tag_term_ff <= cmd.term;

      case (tag_ff)
         fia_pkg::MS_RX2:   dsq_ff   <= prod_ff[66:0];
         fia_pkg::MS_RY2,
         fia_pkg::MS_RZ2:   dsq_ff   <= dsq_ff + prod_ff[66:0];
         fia_pkg::MS_RMIN2: rmin2_ff <= prod_ff[61:0];
         fia_pkg::MS_RMAX2: rmax2_ff <= prod_ff[61:0];
         fia_pkg::MS_VX2:   r2_ff    <= prod_ff[61:0];
         fia_pkg::MS_VY2,
         fia_pkg::MS_VZ2:   r2_ff    <= r2_ff + prod_ff[61:0];
         fia_pkg::MS_DOTX:  dot_ff   <= prod_ff[47:0];
         fia_pkg::MS_DOTY,
         fia_pkg::MS_DOTZ:  dot_ff   <= dot_ff + prod_ff[47:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= fia_pkg::MS_NONE;
      end else begin
         tag_ff <= cmd.mul;
      end
   end

   // ---- normalizer and CORDIC share the vector registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         fia_pkg::OP_NORM_LOAD2: begin
            vec_ff[0] <= VW'(rel_ff[0]);
            vec_ff[1] <= VW'(rel_ff[1]);
            vec_ff[2] <= '0;
         end
         fia_pkg::OP_NORM_LOAD3: begin
            vec_ff[0] <= VW'(rel_ff[0]);
            vec_ff[1] <= VW'(rel_ff[1]);
            vec_ff[2] <= VW'(rel_ff[2]);
         end
         fia_pkg::OP_NORM_STEP: begin
            if (norm_hi) begin
               vec_ff[0] <= vec_ff[0] >>> 1;
               vec_ff[1] <= vec_ff[1] >>> 1;
               vec_ff[2] <= vec_ff[2] >>> 1;
            end else if (!vmax[29] && vmax != '0) begin
               vec_ff[0] <= vec_ff[0] <<< 1;
               vec_ff[1] <= vec_ff[1] <<< 1;
               vec_ff[2] <= vec_ff[2] <<< 1;
            end
         end
         fia_pkg::OP_CORD_INIT: begin
            // left half plane: rotate by half a turn first
            if (vec_ff[0][VW-1]) begin
               vec_ff[0] <= -vec_ff[0];
               vec_ff[1] <= -vec_ff[1];
               ang_ff    <= 32'h8000_0000;
            end else begin
               ang_ff    <= '0;
            end
         end
         fia_pkg::OP_CORD_STEP: begin
            if (!vec_ff[1][VW-1]) begin
               vec_ff[0] <= vec_ff[0] + cy_sh;
               vec_ff[1] <= vec_ff[1] - cx_sh;
               ang_ff    <= ang_ff + cord_atan;
            end else begin
               vec_ff[0] <= vec_ff[0] - cy_sh;
               vec_ff[1] <= vec_ff[1] + cx_sh;
               ang_ff    <= ang_ff - cord_atan;
            end
         end
         default: ;
      endcase
   end

   // ---- bit-pair square root and restoring divider
   always_ff @(posedge clock) begin
      case (cmd.op)
         fia_pkg::OP_SQRT_INIT: begin
            sq_x_ff   <= r2_ff;
            sq_res_ff <= '0;
            sq_bit_ff <= 63'(1) << 62;
         end
         fia_pkg::OP_SQRT_STEP: begin
            if (sq_take) begin
               sq_x_ff   <= sq_x_ff - sq_try[61:0];
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         fia_pkg::OP_DIV_INIT: begin
            // quotient is known to fit QW bits, so the top part starts below the root
            rem_ff <= 31'(dot_mag[47:QW]);
            low_ff <= dot_mag[QW-1:0];
            quo_ff <= '0;
         end
         fia_pkg::OP_DIV_STEP: begin
            if (div_take) begin
               rem_ff <= 31'(div_try - {1'b0, root_q});
            end else begin
               rem_ff <= div_try[30:0];
            end
            low_ff <= low_ff << 1;
            quo_ff <= {quo_ff[QW-2:0], div_take};
         end
         default: ;
      endcase
   end

   // ---- saturating sums and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            sum_ff[k] <= '0;
         end
         sat_ff <= 1'b0;
      end else if (cmd.op == fia_pkg::OP_EMIT) begin
         for (int k = 0; k < 6; k++) begin
            sum_ff[k] <= '0;
         end
         sat_ff <= 1'b0;
      end else if (tag_ff == fia_pkg::MS_WAB) begin
         sum_ff[tag_term_ff] <= sum_new;
         if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            sat_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == fia_pkg::OP_EMIT) begin
         for (int k = 0; k < 6; k++) begin
            info_ff[k] <= 64'(sum_ff[k]);
         end
         info_sat_ff <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == fia_pkg::OP_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.info_xx   = info_ff[0];
   assign rsp.info_xy   = info_ff[1];
   assign rsp.info_xz   = info_ff[2];
   assign rsp.info_yy   = info_ff[3];
   assign rsp.info_yz   = info_ff[4];
   assign rsp.info_zz   = info_ff[5];
   assign rsp.saturated = info_sat_ff;

   assign status.keep_range = (dsq_ff > {5'b0, rmin2_ff}) && (dsq_ff <= {5'b0, rmax2_ff});
   assign status.keep_az    = az_mag <= half_view_ff;
   assign status.norm_done  = !norm_hi && vmax[29];
   assign status.norm_zero  = vmax == '0;
   assign status.last       = last_ff;
   assign status.out_free   = !out_valid_ff || rsp.ready;

endmodule

// ===== hdl/fov_information_accumulator.sv =====
// An accepted point is dropped by the range test or by the azimuth test, or is kept and
// summed. Before the rotations and before the weight the vector is normalized by shifts
// of 0 to 29 places each; a point with no horizontal offset skips the rotations.
// One point in flight; the result beat of a last point is valid when ready returns,
// unless an earlier result beat is still waiting for rsp ready.
// Reset (synchronous): clears the sums and flag, sets registers to defaults.
`timescale 1ns / 1ps

module fov_information_accumulator #(
   parameter int CORDIC_STEPS = 16,
   parameter int SUM_WIDTH    = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   fia_req_if.sink                    req_bus,
   fia_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [fia_pkg::CSR_IW-1:0] csr_index,
   input  logic [fia_pkg::CSR_DW-1:0] csr_wdata
);

   fia_pkg::dp_cmd_type    cmd;
   fia_pkg::dp_status_type status;
   logic                   ready;

   assign req_bus.ready = ready;

   fia_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   fia_dp #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .point_x    (req_bus.point_x),
      .point_y    (req_bus.point_y),
      .point_z    (req_bus.point_z),
      .normal_x   (req_bus.normal_x),
      .normal_y   (req_bus.normal_y),
      .normal_z   (req_bus.normal_z),
      .last_point (req_bus.last_point),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp_bus)
   );

endmodule
